FILE: sv/routine_declaration_scanner_core_defines.svh
// assertion macros shared by the scanner rtl
`ifndef ROUTINE_DECLARATION_SCANNER_CORE_DEFINES_SVH
`define ROUTINE_DECLARATION_SCANNER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rds_pkg.sv
package rds_pkg;

  // keyword being matched
  typedef enum logic [2:0] {
    KW_E_PREFIX       = 3'd0,
    KW_END            = 3'd1,
    KW_EXIT           = 3'd2,
    KW_FUNCTION       = 3'd3,
    KW_SUB            = 3'd4,
    KW_CLOSE_FUNCTION = 3'd5,
    KW_CLOSE_SUB      = 3'd6
  } kw_e;

  // scanner position
  typedef enum logic [7:0] {
    MODE_DECIDE    = 8'b0000_0001,
    MODE_CLOSER    = 8'b0000_0010,
    MODE_KEY       = 8'b0000_0100,
    MODE_AFTER_KEY = 8'b0000_1000,
    MODE_NAME_WAIT = 8'b0001_0000,
    MODE_NAME      = 8'b0010_0000,
    MODE_STRING    = 8'b0100_0000,
    MODE_SKIP_LINE = 8'b1000_0000
  } scan_mode_e;

  // item sequencer
  typedef enum logic [2:0] {
    SEQ_IDLE = 3'b001,
    SEQ_EXEC = 3'b010,
    SEQ_REDO = 3'b100
  } seq_e;

  localparam int unsigned ProgW = 3;

  // classifier flags for one character
  typedef struct packed {
    logic space;
    logic ident;
    logic quote;
    logic apos;
    logic lc_e;
    logic lc_f;
    logic lc_s;
    logic lc_n;
    logic lc_x;
    logic kw_hit;
  } char_class_t;

  function automatic logic [3:0] kw_len(kw_e which);
    logic [3:0] len;
    unique case (which)
      KW_E_PREFIX:       len = 4'd1;
      KW_END:            len = 4'd3;
      KW_EXIT:           len = 4'd4;
      KW_FUNCTION:       len = 4'd8;
      KW_SUB:            len = 4'd3;
      KW_CLOSE_FUNCTION: len = 4'd8;
      KW_CLOSE_SUB:      len = 4'd3;
      default:           len = 4'd0;
    endcase
    return len;
  endfunction

  // expected lower-case keyword character at a given position
  function automatic logic [7:0] kw_char(kw_e which, logic [ProgW-1:0] pos);
    logic [63:0] txt;
    logic [63:0] shifted;
    unique case (which)
      KW_E_PREFIX:       txt = {"e", 56'h0};
      KW_END:            txt = {"end", 40'h0};
      KW_EXIT:           txt = {"exit", 32'h0};
      KW_FUNCTION:       txt = "function";
      KW_SUB:            txt = {"sub", 40'h0};
      KW_CLOSE_FUNCTION: txt = "function";
      KW_CLOSE_SUB:      txt = {"sub", 40'h0};
      default:           txt = 64'h0;
    endcase
    shifted = txt << {pos, 3'b000};
    return shifted[63:56];
  endfunction

endpackage

FILE: sv/rds_classify.sv
module rds_classify (
  input  logic [7:0]                 char_i,
  input  rds_pkg::kw_e               which_i,
  input  logic [rds_pkg::ProgW-1:0]  prog_i,
  output rds_pkg::char_class_t       cls_o
);

  logic [7:0] lc;

  // fold upper case onto lower case
  assign lc = (char_i >= "A" && char_i <= "Z") ? (char_i | 8'h20) : char_i;

  always_comb begin
    cls_o.space  = (char_i == 8'h20) || (char_i >= 8'h09 && char_i <= 8'h0D);
    cls_o.ident  = (char_i >= "0" && char_i <= "9") || (lc >= "a" && lc <= "z")
                   || (char_i == "_");
    cls_o.quote  = (char_i == 8'h22);
    cls_o.apos   = (char_i == 8'h27);
    cls_o.lc_e   = (lc == "e");
    cls_o.lc_f   = (lc == "f");
    cls_o.lc_s   = (lc == "s");
    cls_o.lc_n   = (lc == "n");
    cls_o.lc_x   = (lc == "x");
    cls_o.kw_hit = ({1'b0, prog_i} < rds_pkg::kw_len(which_i))
                   && (lc == rds_pkg::kw_char(which_i, prog_i));
  end

endmodule

FILE: sv/routine_declaration_scanner_core.sv
// an accepted item is worked in the following cycle, and a full output register
//   stalls that work cycle; its result, if any, is registered as the work completes
// the sequencer runs idle, work and idle again, with a redo pass when a keyword mismatch
//   re-runs the character through the shared classifier; items are taken only while idle
// reset: rst_ni is asynchronous, active low; scanner returns to line start
`include "routine_declaration_scanner_core_defines.svh"

module routine_declaration_scanner_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       line_marker_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] name_byte_o,
  output logic       routine_kind_o,
  output logic       name_last_o
);

  typedef struct packed {
    rds_pkg::scan_mode_e        mode;
    rds_pkg::kw_e               which;
    logic [rds_pkg::ProgW-1:0]  prog;
  } scan_next_t;

  // sequencer and input latch
  rds_pkg::seq_e seq_q, seq_d;
  logic [7:0]    char_q;
  logic          marker_q;

  // scanner state
  rds_pkg::scan_mode_e        mode_q;
  rds_pkg::kw_e               which_q;
  logic [rds_pkg::ProgW-1:0]  prog_q;
  logic [7:0]                 held_q;
  logic                       kind_q;

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_kind_q;
  logic       out_last_q;

  rds_pkg::char_class_t cls;
  scan_next_t           step_nxt;
  scan_next_t           redo_nxt;
  logic                 emit;
  logic                 emit_last;
  logic                 redo;
  logic                 held_load;
  logic                 kind_load;
  logic                 out_busy;
  logic                 exec_go;
  logic                 emit_go;
  logic [3:0]           prog_inc;
  rds_pkg::kw_e         key_which;
  logic                 key_ok;

  // decision position: whitespace, string, comment, or keyword start
  function automatic scan_next_t decide(rds_pkg::char_class_t c, logic closer,
                                        scan_next_t cur);
    scan_next_t n;
    n = cur;
    priority if (c.space) begin
      n.mode = closer ? rds_pkg::MODE_CLOSER : rds_pkg::MODE_DECIDE;
    end else if (c.quote) begin
      n.mode = rds_pkg::MODE_STRING;
    end else if (c.apos) begin
      n.mode = rds_pkg::MODE_SKIP_LINE;
    end else if (c.lc_e) begin
      n.mode  = rds_pkg::MODE_KEY;
      n.which = rds_pkg::KW_E_PREFIX;
      n.prog  = rds_pkg::ProgW'(1);
    end else if (c.lc_f) begin
      n.mode  = rds_pkg::MODE_KEY;
      n.which = closer ? rds_pkg::KW_CLOSE_FUNCTION : rds_pkg::KW_FUNCTION;
      n.prog  = rds_pkg::ProgW'(1);
    end else if (c.lc_s) begin
      n.mode  = rds_pkg::MODE_KEY;
      n.which = closer ? rds_pkg::KW_CLOSE_SUB : rds_pkg::KW_SUB;
      n.prog  = rds_pkg::ProgW'(1);
    end else begin
      n.mode = rds_pkg::MODE_DECIDE;
    end
    return n;
  endfunction

  // shared character classifier and keyword comparator
  rds_classify u_classify (
    .char_i  (char_q),
    .which_i (which_q),
    .prog_i  (prog_q),
    .cls_o   (cls)
  );

  assign in_ready_o = (seq_q == rds_pkg::SEQ_IDLE);
  assign out_busy   = out_valid_q && !out_ready_i;

  // keyword step: the e prefix forks into end or exit
  always_comb begin
    key_which = which_q;
    key_ok    = 1'b0;
    if (which_q == rds_pkg::KW_E_PREFIX) begin
      if (cls.lc_n) begin
        key_which = rds_pkg::KW_END;
        key_ok    = 1'b1;
      end else if (cls.lc_x) begin
        key_which = rds_pkg::KW_EXIT;
        key_ok    = 1'b1;
      end
    end else begin
      key_ok = cls.kw_hit;
    end
  end

  assign prog_inc = {1'b0, prog_q} + 4'd1;

  // one scan step for the latched item
  always_comb begin
    scan_next_t cur;
    cur       = '{mode: mode_q, which: which_q, prog: prog_q};
    step_nxt  = cur;
    emit      = 1'b0;
    emit_last = 1'b0;
    redo      = 1'b0;
    held_load = 1'b0;
    kind_load = 1'b0;
    if (marker_q) begin
      // line end flushes a pending name and clears partial matches
      emit      = (mode_q == rds_pkg::MODE_NAME);
      emit_last = 1'b1;
      step_nxt  = '{mode: rds_pkg::MODE_DECIDE, which: rds_pkg::KW_E_PREFIX,
                    prog: '0};
    end else begin
      unique case (mode_q)
        rds_pkg::MODE_DECIDE: step_nxt = decide(cls, 1'b0, cur);
        rds_pkg::MODE_CLOSER: step_nxt = decide(cls, 1'b1, cur);
        rds_pkg::MODE_KEY: begin
          if (!key_ok) begin
            // mismatch: re-examine this character as a fresh decision
            step_nxt.prog = '0;
            redo          = 1'b1;
          end else begin
            step_nxt.which = key_which;
            if (prog_inc >= rds_pkg::kw_len(key_which)) begin
              step_nxt.prog = '0;
              step_nxt.mode = (key_which == rds_pkg::KW_CLOSE_FUNCTION ||
                               key_which == rds_pkg::KW_CLOSE_SUB)
                              ? rds_pkg::MODE_SKIP_LINE : rds_pkg::MODE_AFTER_KEY;
            end else begin
              step_nxt.prog = prog_inc[rds_pkg::ProgW-1:0];
            end
          end
        end
        rds_pkg::MODE_AFTER_KEY: begin
          if (cls.space) begin
            if (which_q == rds_pkg::KW_END || which_q == rds_pkg::KW_EXIT) begin
              step_nxt.mode = rds_pkg::MODE_CLOSER;
            end else if (which_q == rds_pkg::KW_FUNCTION ||
                         which_q == rds_pkg::KW_SUB) begin
              kind_load     = 1'b1;
              step_nxt.mode = rds_pkg::MODE_NAME_WAIT;
            end else begin
              step_nxt.mode = rds_pkg::MODE_DECIDE;
            end
          end else begin
            step_nxt = decide(cls, 1'b0, cur);
          end
        end
        rds_pkg::MODE_NAME_WAIT: begin
          if (cls.space) begin
            step_nxt = cur;
          end else if (cls.ident) begin
            held_load     = 1'b1;
            step_nxt.mode = rds_pkg::MODE_NAME;
          end else begin
            step_nxt = decide(cls, 1'b0, cur);
          end
        end
        rds_pkg::MODE_NAME: begin
          // held character goes out once the next one tells if it was last
          emit = 1'b1;
          if (cls.ident) begin
            held_load = 1'b1;
          end else begin
            emit_last = 1'b1;
            step_nxt  = decide(cls, 1'b0, cur);
          end
        end
        rds_pkg::MODE_STRING: begin
          if (cls.quote) begin
            step_nxt.mode = rds_pkg::MODE_DECIDE;
          end
        end
        rds_pkg::MODE_SKIP_LINE: step_nxt = cur;
        default:                 step_nxt = decide(cls, 1'b0, cur);
      endcase
    end
  end

  // second pass after a mismatch
  always_comb begin
    scan_next_t cur;
    cur      = '{mode: mode_q, which: which_q, prog: prog_q};
    redo_nxt = decide(cls, 1'b0, cur);
  end

  assign exec_go = (seq_q == rds_pkg::SEQ_EXEC) && !(emit && out_busy);
  assign emit_go = exec_go && emit;

  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      rds_pkg::SEQ_IDLE: if (in_valid_i) seq_d = rds_pkg::SEQ_EXEC;
      rds_pkg::SEQ_EXEC: if (exec_go) seq_d = redo ? rds_pkg::SEQ_REDO : rds_pkg::SEQ_IDLE;
      rds_pkg::SEQ_REDO: seq_d = rds_pkg::SEQ_IDLE;
      default:           seq_d = rds_pkg::SEQ_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= rds_pkg::SEQ_IDLE;
      mode_q      <= rds_pkg::MODE_DECIDE;
      which_q     <= rds_pkg::KW_E_PREFIX;
      prog_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      out_valid_q <= out_valid_d;
      if (exec_go) begin
        mode_q  <= step_nxt.mode;
        which_q <= step_nxt.which;
        prog_q  <= step_nxt.prog;
      end else if (seq_q == rds_pkg::SEQ_REDO) begin
        mode_q  <= redo_nxt.mode;
        which_q <= redo_nxt.which;
        prog_q  <= redo_nxt.prog;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q   <= text_byte_i;
      marker_q <= line_marker_i;
    end
    if (exec_go && held_load) begin
      held_q <= char_q;
    end
    if (exec_go && kind_load) begin
      kind_q <= (which_q == rds_pkg::KW_SUB);
    end
    if (emit_go) begin
      out_byte_q <= held_q;
      out_kind_q <= kind_q;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign name_byte_o    = out_byte_q;
  assign routine_kind_o = out_kind_q;
  assign name_last_o    = out_last_q;

  // the second pass only follows a keyword mismatch in the work cycle
  `RDS_ASSERT_IMP(a_redo_after_exec, seq_q == rds_pkg::SEQ_REDO, $past(seq_q) == rds_pkg::SEQ_EXEC && $past(mode_q) == rds_pkg::MODE_KEY, "redo without keyword mismatch")
  // a name character is only sent while a name is being collected
  `RDS_ASSERT_IMP(a_emit_in_name, emit_go, mode_q == rds_pkg::MODE_NAME, "result outside a name")
  // a partial keyword always has at least one matched character
  `RDS_ASSERT_IMP(a_key_progress, mode_q == rds_pkg::MODE_KEY && seq_q != rds_pkg::SEQ_REDO, prog_q != '0, "keyword match with no progress")
  // a stalled result blocks the work cycle from emitting another
  `RDS_ASSERT_NXT(a_no_overwrite, seq_q == rds_pkg::SEQ_EXEC && emit && out_busy, seq_q == rds_pkg::SEQ_EXEC, "work cycle left while result stalled")

endmodule

FILE: sim/routine_declaration_scanner_core_checker.sv
`timescale 1ns / 100ps

module routine_declaration_scanner_core_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] text_byte_i,
  input  logic       line_marker_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] name_byte_i,
  input  logic       routine_kind_i,
  input  logic       name_last_i,
  output int         bad_cnt_o,
  output int         waiting_o
);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam int         SHOWN_MAX = 10;

  typedef struct packed {
    logic [7:0] ch;
    logic       kind;
    logic       last;
  } name_char_t;

  // scanner copy
  rds_pkg::scan_mode_e mode;
  rds_pkg::kw_e        kw;
  logic [3:0]          kw_pos;
  logic [7:0]          held_ch;
  logic                held_ok;
  logic                name_kind;

  name_char_t name_chars_q[$];

  function automatic logic is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_word_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
           (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic [7:0] lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic string kw_text(rds_pkg::kw_e w);
    case (w)
      rds_pkg::KW_E_PREFIX:       return "e";
      rds_pkg::KW_END:            return "end";
      rds_pkg::KW_EXIT:           return "exit";
      rds_pkg::KW_FUNCTION:       return "function";
      rds_pkg::KW_SUB:            return "sub";
      rds_pkg::KW_CLOSE_FUNCTION: return "function";
      rds_pkg::KW_CLOSE_SUB:      return "sub";
      default:                    return "";
    endcase
  endfunction

  function automatic void push_name(logic last);
    name_char_t nc;
    nc.ch   = held_ch;
    nc.kind = name_kind;
    nc.last = last;
    name_chars_q.push_back(nc);
  endfunction

  function automatic void open_keyword(rds_pkg::kw_e w);
    mode   = rds_pkg::MODE_KEY;
    kw     = w;
    kw_pos = 4'd1;
  endfunction

  // fresh decision position, closer set after end/exit and a blank
  function automatic void decide(logic [7:0] c, logic closer);
    logic [7:0] lc;
    lc = lower(c);
    if (is_blank(c)) begin
      if (closer) mode = rds_pkg::MODE_CLOSER;
      else mode = rds_pkg::MODE_DECIDE;
    end else if (c == CH_QUOTE) begin
      mode = rds_pkg::MODE_STRING;
    end else if (c == CH_APOS) begin
      mode = rds_pkg::MODE_SKIP_LINE;
    end else if (lc == "e") begin
      open_keyword(rds_pkg::KW_E_PREFIX);
    end else if (lc == "f") begin
      if (closer) open_keyword(rds_pkg::KW_CLOSE_FUNCTION);
      else open_keyword(rds_pkg::KW_FUNCTION);
    end else if (lc == "s") begin
      if (closer) open_keyword(rds_pkg::KW_CLOSE_SUB);
      else open_keyword(rds_pkg::KW_SUB);
    end else begin
      mode = rds_pkg::MODE_DECIDE;
    end
  endfunction

  function automatic void match_keyword(logic [7:0] c);
    logic [7:0] lc;
    string      word;
    lc = lower(c);
    if (kw == rds_pkg::KW_E_PREFIX) begin
      if (lc == "n") kw = rds_pkg::KW_END;
      else if (lc == "x") kw = rds_pkg::KW_EXIT;
      else begin
        kw_pos = 4'd0;
        decide(c, 1'b0);
        return;
      end
    end else begin
      word = kw_text(kw);
      if (kw_pos >= word.len() || lc != word[kw_pos]) begin
        // only the mismatching char is looked at again
        kw_pos = 4'd0;
        decide(c, 1'b0);
        return;
      end
    end
    kw_pos++;
    word = kw_text(kw);
    if (kw_pos >= word.len()) begin
      kw_pos = 4'd0;
      if (kw == rds_pkg::KW_CLOSE_FUNCTION || kw == rds_pkg::KW_CLOSE_SUB) begin
        mode = rds_pkg::MODE_SKIP_LINE;
      end else begin
        mode = rds_pkg::MODE_AFTER_KEY;
      end
    end
  endfunction

  function automatic void scan_item(logic [7:0] c, logic marker);
    if (marker) begin
      if (mode == rds_pkg::MODE_NAME && held_ok) push_name(1'b1);
      mode    = rds_pkg::MODE_DECIDE;
      kw      = rds_pkg::KW_E_PREFIX;
      kw_pos  = 4'd0;
      held_ok = 1'b0;
      return;
    end
    case (mode)
      rds_pkg::MODE_DECIDE: decide(c, 1'b0);
      rds_pkg::MODE_CLOSER: decide(c, 1'b1);
      rds_pkg::MODE_KEY:    match_keyword(c);
      rds_pkg::MODE_AFTER_KEY: begin
        if (is_blank(c)) begin
          if (kw == rds_pkg::KW_END || kw == rds_pkg::KW_EXIT) begin
            mode = rds_pkg::MODE_CLOSER;
          end else if (kw == rds_pkg::KW_FUNCTION || kw == rds_pkg::KW_SUB) begin
            name_kind = (kw == rds_pkg::KW_SUB);
            mode      = rds_pkg::MODE_NAME_WAIT;
          end else begin
            mode = rds_pkg::MODE_DECIDE;
          end
        end else begin
          decide(c, 1'b0);
        end
      end
      rds_pkg::MODE_NAME_WAIT: begin
        if (is_blank(c)) begin
          mode = rds_pkg::MODE_NAME_WAIT;
        end else if (is_word_char(c)) begin
          held_ch = c;
          held_ok = 1'b1;
          mode    = rds_pkg::MODE_NAME;
        end else begin
          decide(c, 1'b0);
        end
      end
      rds_pkg::MODE_NAME: begin
        if (is_word_char(c)) begin
          if (held_ok) push_name(1'b0);
          held_ch = c;
          held_ok = 1'b1;
        end else begin
          if (held_ok) push_name(1'b1);
          held_ok = 1'b0;
          decide(c, 1'b0);
        end
      end
      rds_pkg::MODE_STRING: begin
        if (c == CH_QUOTE) mode = rds_pkg::MODE_DECIDE;
      end
      rds_pkg::MODE_SKIP_LINE: ;
      default: decide(c, 1'b0);
    endcase
  endfunction

  function automatic void check_result();
    name_char_t want;
    if (name_chars_q.size() == 0) begin
      bad_cnt_o++;
      if (bad_cnt_o <= SHOWN_MAX)
        $display("%0t: unexpected name item: byte %h kind %0d last %0d",
                 $time, name_byte_i, routine_kind_i, name_last_i);
      return;
    end
    want = name_chars_q.pop_front();
    if (want.ch !== name_byte_i || want.kind !== routine_kind_i ||
        want.last !== name_last_i) begin
      bad_cnt_o++;
      if (bad_cnt_o <= SHOWN_MAX)
        $display("%0t: name item mismatch: want %h/%0d/%0d got %h/%0d/%0d",
                 $time, want.ch, want.kind, want.last,
                 name_byte_i, routine_kind_i, name_last_i);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode      = rds_pkg::MODE_DECIDE;
      kw        = rds_pkg::KW_E_PREFIX;
      kw_pos    = 4'd0;
      held_ch   = 8'h00;
      held_ok   = 1'b0;
      name_kind = 1'b0;
      name_chars_q.delete();
      bad_cnt_o = 0;
      waiting_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) scan_item(text_byte_i, line_marker_i);
      if (out_valid_i && out_ready_i) check_result();
      waiting_o = name_chars_q.size();
    end
  end

endmodule

FILE: sim/routine_declaration_scanner_core_tb.sv
`timescale 1ns / 100ps

module routine_declaration_scanner_core_tb;

  localparam int         RESET_CYCLES  = 12;
  localparam int         CYCLE_LIMIT   = 400000;
  // settle time before the final check; a result is registered when its item is worked
  localparam int         SETTLE_CYCLES = 8;
  localparam int         HOLD_CYCLES   = 400;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_APOS       = 8'h27;
  localparam logic [7:0] CH_TAB        = 8'h09;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_ready;
  logic [7:0] text_byte   = 8'h00;
  logic       line_marker = 1'b0;
  logic       out_valid;
  logic       out_ready   = 1'b0;
  logic [7:0] name_byte;
  logic       routine_kind;
  logic       name_last;

  int   bad_cnt;
  int   waiting;
  int   sent_cnt    = 0;
  int   cycle_cnt   = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic hold_rx     = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  routine_declaration_scanner_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .text_byte_i    (text_byte),
    .line_marker_i  (line_marker),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .name_byte_o    (name_byte),
    .routine_kind_o (routine_kind),
    .name_last_o    (name_last)
  );

  // predicts name items from the accepted text items and compares them
  routine_declaration_scanner_core_checker scan_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .text_byte_i    (text_byte),
    .line_marker_i  (line_marker),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .name_byte_i    (name_byte),
    .routine_kind_i (routine_kind),
    .name_last_i    (name_last),
    .bad_cnt_o      (bad_cnt),
    .waiting_o      (waiting)
  );

  // receiver: random stalls, or a long hold while hold_rx is up
  always @(negedge clk) begin
    out_ready <= !hold_rx && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("routine_declaration_scanner_core test failed");
      $finish;
    end
  end

  // offer one item, entered and left at a falling edge; valid stays up between
  // back-to-back items so only one assignment lands per edge
  task automatic send_item(input logic [7:0] b, input logic m);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    text_byte   <= b;
    line_marker <= m;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_cnt++;
  endtask

  // line end, with a junk byte that the block has to ignore
  task automatic send_eol();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // text, with letters flipped to random case when mix is set
  task automatic send_word(input string w, input logic mix);
    logic [7:0] c;
    for (int i = 0; i < w.len(); i++) begin
      c = w[i];
      if (mix && ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
          $urandom_range(0, 1) == 1)
        c = c ^ 8'h20;
      send_item(c, 1'b0);
    end
  endtask

  // space or one of tab..carriage return
  task automatic send_blanks(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 7);
      if (r < 3) send_item(8'h20, 1'b0);
      else send_item(CH_TAB + 8'(r - 3), 1'b0);
    end
  endtask

  // identifier chars: digits, both cases, underscore
  task automatic send_name(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 62);
      if (r < 10) send_item(8'("0" + r), 1'b0);
      else if (r < 36) send_item(8'("A" + r - 10), 1'b0);
      else if (r < 62) send_item(8'("a" + r - 36), 1'b0);
      else send_item(8'h5F, 1'b0);
    end
  endtask

  // raw bytes over the whole range, high bit and zero included
  task automatic send_noise(input int n);
    repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
  endtask

  function automatic string either(input string a, input string b);
    if ($urandom_range(0, 1) == 1) return a;
    return b;
  endfunction

  // broken and glued keyword pieces that push the matcher into mismatches
  function automatic string pick_fragment();
    case ($urandom_range(0, 15))
      0:  return "fun";
      1:  return "functio";
      2:  return "su";
      3:  return "e";
      4:  return "en";
      5:  return "ex";
      6:  return "exi";
      7:  return "end";
      8:  return "exit";
      9:  return "sub";
      10: return "function";
      11: return "endsub";
      12: return "exitfunction";
      13: return "sufunction";
      14: return "ff";
      default: return "s_e";
    endcase
  endfunction

  // one line of script text: declarations, closers, quoted text, comments, fragments or noise
  task automatic send_line();
    int pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) send_blanks($urandom_range(1, 3));
    if (pick < 40) begin
      // declaration, sometimes glued to junk or with no name at all
      if ($urandom_range(0, 4) == 0) send_word(pick_fragment(), 1'b1);
      send_word(either("function", "sub"), 1'b1);
      if ($urandom_range(0, 6) != 0) send_blanks($urandom_range(1, 3));
      if ($urandom_range(0, 7) != 0) send_name($urandom_range(1, 10));
      case ($urandom_range(0, 3))
        0: begin
          send_word("(", 1'b0);
          send_name($urandom_range(0, 4));
          send_word(")", 1'b0);
        end
        1: begin
          send_blanks(1);
          send_item(CH_APOS, 1'b0);
          send_word(" sub hidden", 1'b1);
        end
        2: send_word(pick_fragment(), 1'b1);
        default: ;
      endcase
    end else if (pick < 52) begin
      // closers: end/exit followed by function, sub or some other word
      send_word(either("end", "exit"), 1'b1);
      if ($urandom_range(0, 5) != 0) send_blanks($urandom_range(1, 2));
      case ($urandom_range(0, 3))
        0: send_word("function", 1'b1);
        1: send_word("sub", 1'b1);
        2: send_word("if", 1'b1);
        default: send_word(pick_fragment(), 1'b1);
      endcase
      send_blanks(1);
      send_word("sub ", 1'b1);
      send_name($urandom_range(1, 4));
    end else if (pick < 62) begin
      // quoted text, closed most of the time, then a declaration
      send_item(CH_QUOTE, 1'b0);
      send_word("function f ", 1'b1);
      send_word(pick_fragment(), 1'b1);
      if ($urandom_range(0, 3) != 0) send_item(CH_QUOTE, 1'b0);
      send_word("sub ", 1'b1);
      send_name($urandom_range(1, 5));
    end else if (pick < 70) begin
      // trailing comment hides a declaration
      send_word("x = 1 ", 1'b0);
      send_item(CH_APOS, 1'b0);
      send_word("function hidden", 1'b1);
    end else if (pick < 85) begin
      repeat ($urandom_range(1, 4)) begin
        send_word(pick_fragment(), 1'b1);
        if ($urandom_range(0, 1) == 1) send_blanks(1);
        if ($urandom_range(0, 2) == 0) send_name($urandom_range(1, 3));
      end
    end else begin
      send_noise($urandom_range(1, 10));
    end
    if ($urandom_range(0, 6) != 0) send_eol();
  endtask

  // sender stops until every predicted name item has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (waiting == 0);
    @(negedge clk);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int upto);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (sent_cnt < upto) send_line();
    drain_results();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed part, no idling
    // "fusub": function match fails at the s, which then starts sub
    send_word("fusub a(", 1'b0);
    // end glued to function, upper case, tab before the name, name ends at line end
    send_word("endFUNCTION", 1'b0);
    send_item(CH_TAB, 1'b0);
    send_word("Z_9", 1'b0);
    send_eol();
    // closing quote consumed, then an apostrophe drops the rest
    send_item(CH_QUOTE, 1'b0);
    send_word("su", 1'b0);
    send_item(CH_QUOTE, 1'b0);
    send_item(CH_APOS, 1'b0);
    send_word("s", 1'b0);
    send_eol();
    // byte zero and the top byte are plain characters
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h80, 1'b1);
    drain_results();

    // long receiver hold while the sender keeps offering, so the block backs up
    tx_idle_pct = 20;
    rx_idle_pct = 55;
    fork
      begin
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      repeat (12) send_line();
    join

    run_phase(20, 55, 500);
    run_phase(55, 20, 980);
    run_phase(0, 0, 1460);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (bad_cnt == 0 && waiting == 0) begin
      $display("routine_declaration_scanner_core test passed");
    end else begin
      $display("routine_declaration_scanner_core test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/rds_pkg.sv
sv/rds_classify.sv
sv/routine_declaration_scanner_core.sv
sim/routine_declaration_scanner_core_checker.sv
sim/routine_declaration_scanner_core_tb.sv
